// ===== rtl/fstk_pkg.sv =====
// Package for the focus stack merge block: word types, register indexes,
// reset values and gray weights. No dependencies.
package fstk_pkg;

    // Input word: one pixel of one image of the stack
    typedef struct packed {
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
        logic [7:0] in_alpha;
    } in_word_t;

    // Output word: one merged pixel
    typedef struct packed {
        logic [9:0] out_row;
        logic [9:0] out_col;
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
        logic [3:0] chosen_image;
        logic       frame_done;
    } out_word_t;

    // Control from the sequencer to the contrast unit
    typedef struct packed {
        logic clear_best;
        logic start_win;
        logic take;
        logic judge;
    } cu_ctrl_t;

    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

    localparam logic [4:0]  IMAGE_COUNT_RST  = 5'd11;
    localparam logic [10:0] FRAME_WIDTH_RST  = 11'd1024;
    localparam logic [10:0] FRAME_HEIGHT_RST = 11'd1024;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_MAX_IMAGES = 16;

    localparam int GRAY_W = 15;
    localparam logic [GRAY_W-1:0] GRAY_MAX  = 15'd25500;
    localparam logic [GRAY_W-1:0] WT_RED    = 15'd21;
    localparam logic [GRAY_W-1:0] WT_GREEN  = 15'd72;
    localparam logic [GRAY_W-1:0] WT_BLUE   = 15'd7;

endpackage

// ===== rtl/fstk_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fstk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ===== rtl/fstk_contrast.sv =====
// Shared min/max and best-contrast unit for the focus stack merge block.
// Depends on fstk_pkg.
module fstk_contrast
    import fstk_pkg::*;
#(
    parameter int KIX_W = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cu_ctrl_t          ctrl,
    input  logic [GRAY_W-1:0] sample,
    input  logic [KIX_W-1:0]  image_idx,
    output logic [KIX_W-1:0]  best_k
);
    logic [GRAY_W-1:0] lo_reg, hi_reg, best_reg;
    logic              best_valid_reg;
    logic [KIX_W-1:0]  best_k_reg;
    logic [GRAY_W-1:0] contrast;

    assign contrast = hi_reg - lo_reg;
    assign best_k   = best_k_reg;

    // Track window extremes, then keep the first strictly largest contrast
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_valid_reg <= 1'b0;
        end
        else if (ctrl.clear_best)
        begin
            best_valid_reg <= 1'b0;
        end
        else if (ctrl.judge)
        begin
            best_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start_win)
        begin
            lo_reg <= GRAY_MAX;
            hi_reg <= '0;
        end
        else if (ctrl.take)
        begin
            if (sample < lo_reg)
            begin
                lo_reg <= sample;
            end
            if (sample > hi_reg)
            begin
                hi_reg <= sample;
            end
        end
        if (ctrl.judge && (!best_valid_reg || contrast > best_reg))
        begin
            best_reg   <= contrast;
            best_k_reg <= image_idx;
        end
    end
endmodule

// ===== rtl/focus_stack_merge.sv =====
// Focus stack merge top level: sequencer, line stores and output register.
// Depends on fstk_pkg, fstk_ram and fstk_contrast.
//
// Usage: pixels enter on in_valid/in_ready in raster order; at each position
// the words of all images of the stack follow one another, image 0 first.
// Merged pixels leave on out_valid/out_ready with their row and column.
// Configuration is written through cfg_write/cfg_index/cfg_data while idle;
// any write to a known register restarts the frame.
// Flow: a word that is not the last image of a position is taken while the
// sequencer stays idle. The last image of a position produces up to four
// outputs, each worked out by the shared min/max unit, which reads one
// line-store entry per cycle: nine taps plus a flush step and one compare
// per image, then a color read and the hand-off. Each output slot that does
// not exist at this position still passes through the selection state.
// Reset clears counters and loads register defaults (11 images, 1024 x
// 1024); the line stores are not cleared. A stalled receiver holds the
// output register; the next result waits in the sequencer, and a new input
// word is taken once the sequencer is back to idle.
module focus_stack_merge
    import fstk_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_IMAGES = DEF_MAX_IMAGES
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_word_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_word_t             out_data,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);
    localparam int CIX_W  = $clog2(MAX_WIDTH);
    localparam int RIX_W  = $clog2(MAX_HEIGHT);
    localparam int KIX_W  = $clog2(MAX_IMAGES);
    localparam int G_DEPTH = 3 * MAX_WIDTH * MAX_IMAGES;
    localparam int C_DEPTH = 2 * MAX_WIDTH * MAX_IMAGES;
    localparam int GA_W   = $clog2(G_DEPTH);
    localparam int CA_W   = $clog2(C_DEPTH);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_SEL  = 6'b000010,
        ST_TAP  = 6'b000100,
        ST_CMP  = 6'b001000,
        ST_CRD  = 6'b010000,
        ST_EMIT = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [4:0]  img_cnt_reg;
    logic [10:0] width_reg, height_reg;
    logic [31:0] n_eff, w_eff, h_eff;

    logic [RIX_W-1:0] row_reg;
    logic [CIX_W-1:0] col_reg;
    logic [KIX_W-1:0] k_reg;
    logic [1:0]       rm_reg;

    logic [RIX_W-1:0] base_r_reg, er_reg;
    logic [CIX_W-1:0] base_c_reg, ec_reg;
    logic [1:0]       base_rm_reg, erm_reg;
    logic             top_reg, bot_reg, left_reg, right_reg;
    logic [1:0]       e_reg;
    logic [KIX_W-1:0] kk_reg;
    logic [1:0]       tr_reg, tc_reg;
    logic             tap_done_reg, pend_reg;

    out_word_t out_reg;
    logic      out_valid_reg;

    // Clamp the registers to their working ranges
    always_comb
    begin
        n_eff = (img_cnt_reg == '0) ? 32'd1 :
                ((32'(img_cnt_reg) > MAX_IMAGES) ? MAX_IMAGES : 32'(img_cnt_reg));
        w_eff = (width_reg == '0) ? 32'd1 :
                ((32'(width_reg) > MAX_WIDTH) ? MAX_WIDTH : 32'(width_reg));
        h_eff = (height_reg == '0) ? 32'd1 :
                ((32'(height_reg) > MAX_HEIGHT) ? MAX_HEIGHT : 32'(height_reg));
    end

    function automatic logic [GA_W-1:0] gaddr(input logic [1:0] rm,
                                              input logic [CIX_W-1:0] c,
                                              input logic [KIX_W-1:0] k);
        gaddr = GA_W'((GA_W'(rm) * GA_W'(MAX_WIDTH) + GA_W'(c)) * GA_W'(MAX_IMAGES)
                      + GA_W'(k));
    endfunction

    function automatic logic [CA_W-1:0] caddr(input logic rp,
                                              input logic [CIX_W-1:0] c,
                                              input logic [KIX_W-1:0] k);
        caddr = CA_W'((CA_W'(rp) * CA_W'(MAX_WIDTH) + CA_W'(c)) * CA_W'(MAX_IMAGES)
                      + CA_W'(k));
    endfunction

    // Row slot of (row mod 3) shifted by an offset of -1, 0 or +1
    function automatic logic [1:0] slot_step(input logic [1:0] rm, input logic [1:0] t);
        logic [2:0] s;
        s = 3'(rm) + 3'(t) + 3'd2;
        if (s >= 3'd6)
        begin
            slot_step = 2'(s - 3'd6);
        end
        else if (s >= 3'd3)
        begin
            slot_step = 2'(s - 3'd3);
        end
        else
        begin
            slot_step = 2'(s);
        end
    endfunction

    // Input side: position of the incoming word, restarted if out of range
    logic             accept, in_range, last_img;
    logic [RIX_W-1:0] cur_r;
    logic [CIX_W-1:0] cur_c;
    logic [KIX_W-1:0] cur_k;
    logic [1:0]       cur_rm;
    logic [GRAY_W-1:0] gray_in;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign in_range = (32'(row_reg) < h_eff) && (32'(col_reg) < w_eff) &&
                      (32'(k_reg) < n_eff);
    assign cur_r    = in_range ? row_reg : '0;
    assign cur_c    = in_range ? col_reg : '0;
    assign cur_k    = in_range ? k_reg : '0;
    assign cur_rm   = in_range ? rm_reg : 2'd0;
    assign last_img = (32'(cur_k) + 32'd1) >= n_eff;
    assign gray_in  = WT_RED * GRAY_W'(in_data.in_red) + WT_GREEN * GRAY_W'(in_data.in_green)
                    + WT_BLUE * GRAY_W'(in_data.in_blue);

    // Window tap in progress
    logic              rr_ok, cc_ok, tap_issue;
    logic [CIX_W-1:0]  tap_c;
    logic [GRAY_W-1:0] gray_rd;
    logic [31:0]       color_rd;
    logic [KIX_W-1:0]  best_k;
    cu_ctrl_t          cu_ctrl;
    logic              e_ok, out_load;

    assign rr_ok = !(tr_reg == 2'd0 && er_reg == '0) &&
                   !(tr_reg == 2'd2 && (32'(er_reg) + 32'd1) >= h_eff);
    assign cc_ok = !(tc_reg == 2'd0 && ec_reg == '0) &&
                   !(tc_reg == 2'd2 && (32'(ec_reg) + 32'd1) >= w_eff);
    assign tap_c = CIX_W'(32'(ec_reg) + 32'(tc_reg) - 32'd1);
    assign tap_issue = (state_reg == ST_TAP) && !tap_done_reg && rr_ok && cc_ok;
    assign e_ok = (e_reg[1] ? bot_reg : top_reg) && (e_reg[0] ? right_reg : left_reg);
    assign out_load = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);

    fstk_ram #(.WIDTH(GRAY_W), .DEPTH(G_DEPTH)) u_gray_ram (
        .clk   (clk),
        .we    (accept),
        .waddr (gaddr(cur_rm, cur_c, cur_k)),
        .wdata (gray_in),
        .re    (tap_issue),
        .raddr (gaddr(slot_step(erm_reg, tr_reg), tap_c, kk_reg)),
        .rdata (gray_rd)
    );

    fstk_ram #(.WIDTH(32), .DEPTH(C_DEPTH)) u_color_ram (
        .clk   (clk),
        .we    (accept),
        .waddr (caddr(cur_r[0], cur_c, cur_k)),
        .wdata ({in_data.in_alpha, in_data.in_blue, in_data.in_green, in_data.in_red}),
        .re    (state_reg == ST_CRD),
        .raddr (caddr(er_reg[0], ec_reg, best_k)),
        .rdata (color_rd)
    );

    always_comb
    begin
        cu_ctrl.clear_best = (state_reg == ST_SEL);
        cu_ctrl.start_win  = (state_reg == ST_SEL) ||
                             ((state_reg == ST_CMP) && (32'(kk_reg) + 32'd1) < n_eff);
        cu_ctrl.take       = (state_reg == ST_TAP) && pend_reg;
        cu_ctrl.judge      = (state_reg == ST_CMP);
    end

    fstk_contrast #(.KIX_W(KIX_W)) u_contrast (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (cu_ctrl),
        .sample    (gray_rd),
        .image_idx (kk_reg),
        .best_k    (best_k)
    );

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && last_img)
                begin
                    state_next = ST_SEL;
                end
            end
            ST_SEL:
            begin
                if (e_ok)
                begin
                    state_next = ST_TAP;
                end
                else if (e_reg == 2'd3)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_TAP:
            begin
                if (tap_done_reg)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next = ((32'(kk_reg) + 32'd1) < n_eff) ? ST_TAP : ST_CRD;
            end
            ST_CRD:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_load)
                begin
                    state_next = (e_reg == 2'd3) ? ST_IDLE : ST_SEL;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers: state, configuration, counters, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            img_cnt_reg   <= IMAGE_COUNT_RST;
            width_reg     <= FRAME_WIDTH_RST;
            height_reg    <= FRAME_HEIGHT_RST;
            row_reg       <= '0;
            col_reg       <= '0;
            k_reg         <= '0;
            rm_reg        <= 2'd0;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= tap_issue;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_write && (cfg_index == REG_IMAGE_COUNT || cfg_index == REG_FRAME_WIDTH ||
                              cfg_index == REG_FRAME_HEIGHT))
            begin
                case (cfg_index)
                    REG_IMAGE_COUNT:  img_cnt_reg <= cfg_data[4:0];
                    REG_FRAME_WIDTH:  width_reg   <= cfg_data;
                    REG_FRAME_HEIGHT: height_reg  <= cfg_data;
                    default:          img_cnt_reg <= img_cnt_reg;
                endcase
                row_reg <= '0;
                col_reg <= '0;
                k_reg   <= '0;
                rm_reg  <= 2'd0;
            end
            else if (accept)
            begin
                // Advance image, then column, then row
                if (!last_img)
                begin
                    k_reg   <= cur_k + 1'b1;
                    row_reg <= cur_r;
                    col_reg <= cur_c;
                    rm_reg  <= cur_rm;
                end
                else
                begin
                    k_reg <= '0;
                    if ((32'(cur_c) + 32'd1) < w_eff)
                    begin
                        col_reg <= cur_c + 1'b1;
                        row_reg <= cur_r;
                        rm_reg  <= cur_rm;
                    end
                    else
                    begin
                        col_reg <= '0;
                        if ((32'(cur_r) + 32'd1) < h_eff)
                        begin
                            row_reg <= cur_r + 1'b1;
                            rm_reg  <= slot_step(cur_rm, 2'd2);
                        end
                        else
                        begin
                            row_reg <= '0;
                            rm_reg  <= 2'd0;
                        end
                    end
                end
            end
        end
    end

    // Emit bookkeeping, window taps and output word
    always_ff @(posedge clk)
    begin
        if (accept && last_img)
        begin
            base_r_reg  <= cur_r;
            base_c_reg  <= cur_c;
            base_rm_reg <= cur_rm;
            top_reg     <= (cur_r != '0);
            bot_reg     <= (32'(cur_r) + 32'd1) == h_eff;
            left_reg    <= (cur_c != '0);
            right_reg   <= (32'(cur_c) + 32'd1) == w_eff;
            e_reg       <= 2'd0;
        end
        if (state_reg == ST_SEL)
        begin
            if (!e_ok)
            begin
                e_reg <= e_reg + 2'd1;
            end
            er_reg       <= e_reg[1] ? base_r_reg : base_r_reg - 1'b1;
            erm_reg      <= e_reg[1] ? base_rm_reg : slot_step(base_rm_reg, 2'd0);
            ec_reg       <= e_reg[0] ? base_c_reg : base_c_reg - 1'b1;
            kk_reg       <= '0;
            tr_reg       <= 2'd0;
            tc_reg       <= 2'd0;
            tap_done_reg <= 1'b0;
        end
        if (state_reg == ST_TAP && !tap_done_reg)
        begin
            if (tc_reg == 2'd2)
            begin
                tc_reg <= 2'd0;
                tr_reg <= tr_reg + 2'd1;
                if (tr_reg == 2'd2)
                begin
                    tap_done_reg <= 1'b1;
                end
            end
            else
            begin
                tc_reg <= tc_reg + 2'd1;
            end
        end
        if (state_reg == ST_CMP)
        begin
            kk_reg       <= kk_reg + 1'b1;
            tr_reg       <= 2'd0;
            tc_reg       <= 2'd0;
            tap_done_reg <= 1'b0;
        end
        if (out_load)
        begin
            e_reg                <= e_reg + 2'd1;
            out_reg.out_row      <= 10'(er_reg);
            out_reg.out_col      <= 10'(ec_reg);
            out_reg.out_red      <= color_rd[7:0];
            out_reg.out_green    <= color_rd[15:8];
            out_reg.out_blue     <= color_rd[23:16];
            out_reg.out_alpha    <= color_rd[31:24];
            out_reg.chosen_image <= 4'(best_k);
            out_reg.frame_done   <= ((32'(er_reg) + 32'd1) == h_eff) &&
                                    ((32'(ec_reg) + 32'd1) == w_eff);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // The column counter stays inside the frame
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(col_reg) < w_eff)
        else $error("column counter outside frame");

    // Last image of a position starts the emit scan
    a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_img |=> state_reg == ST_SEL)
        else $error("emit scan not started");

    // A sample is taken only after a tap read issued
    a_pend_tap: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> $past(state_reg == ST_TAP))
        else $error("stray line store sample");

    // Loading the output register raises valid
    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid_reg)
        else $error("output word lost");

endmodule
